// ===== rtl/mssd_pkg.sv =====
// Shared types, constants and glyph tables for the seven-segment display driver.
// No dependencies; imported by every module in rtl/.
package mssd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SEG_A  = 8'h80;
  localparam logic [7:0] SEG_B  = 8'h40;
  localparam logic [7:0] SEG_F  = 8'h20;
  localparam logic [7:0] SEG_G  = 8'h10;
  localparam logic [7:0] SEG_C  = 8'h08;
  localparam logic [7:0] SEG_DP = 8'h04;
  localparam logic [7:0] SEG_D  = 8'h02;
  localparam logic [7:0] SEG_E  = 8'h01;

  localparam logic [7:0] GLYPH_UPPER_C = SEG_A | SEG_F | SEG_D | SEG_E;
  localparam logic [7:0] GLYPH_UPPER_E = SEG_A | SEG_F | SEG_G | SEG_E | SEG_D;
  localparam logic [7:0] GLYPH_LOWER_R = SEG_E | SEG_G;
  localparam logic [7:0] GLYPH_BLANK   = 8'h00;

  localparam logic [9:0] TEMP_MAX     = 10'd999;
  localparam logic [3:0] CODE_OK      = 4'd0;
  localparam logic [3:0] CODE_MAX_DIG = 4'd9;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_TEMP = 2'd1,
    OP_ERR  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] hund;   // temperature / 100
    logic [6:0] rem;    // temperature % 100
    logic [3:0] code;
  } item_t;

  typedef struct packed {
    logic [7:0] seg_code;
    logic [7:0] digit_select;
    logic       latch_pulse;
    logic       accepted;
  } result_t;

  function automatic logic [7:0] numeral_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    g = SEG_B | SEG_C;
      4'd2:    g = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
      4'd3:    g = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
      4'd4:    g = SEG_F | SEG_G | SEG_B | SEG_C;
      4'd5:    g = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      4'd6:    g = SEG_A | SEG_F | SEG_G | SEG_E | SEG_D | SEG_C;
      4'd7:    g = SEG_A | SEG_B | SEG_C;
      4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] select_byte(input int idx);
    logic [7:0] s;
    unique case (idx)
      0:       s = 8'h04;
      1:       s = 8'h20;
      2:       s = 8'h08;
      3:       s = 8'h40;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] reset_glyph(input int idx);
    logic [7:0] g;
    unique case (idx)
      0:       g = numeral_glyph(4'd1);
      1:       g = numeral_glyph(4'd2);
      2:       g = numeral_glyph(4'd3);
      3:       g = numeral_glyph(4'd5);
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/mssd_front.sv =====
// Front end: classifies the incoming op and splits the saturated temperature
// into hundreds and remainder. Depends on mssd_pkg.
module mssd_front import mssd_pkg::*; (
  input  logic [1:0] op,
  input  logic [9:0] temp_tenths,
  input  logic [3:0] error_code,
  output item_t      item
);

  logic [9:0]  t_sat;
  logic [15:0] prod;
  logic [3:0]  hund;
  logic [9:0]  hund_x100;

  always_comb begin
    t_sat     = (temp_tenths > TEMP_MAX) ? TEMP_MAX : temp_tenths;
    // t / 100 == (t * 41) >> 12 for t < 1024
    prod      = 16'(t_sat) * 16'd41;
    hund      = prod[15:12];
    hund_x100 = 10'(hund) * 10'd100;
    item.op   = op_t'(op);
    item.hund = hund;
    item.rem  = 7'(t_sat - hund_x100);
    item.code = error_code;
  end

endmodule

// ===== rtl/mssd_queue.sv =====
// Two-entry queue between the front and back ends.
// Depends on mssd_pkg.
module mssd_queue import mssd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W:0]     count;

  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/mssd_back.sv =====
// Back end: digit store, scan index, error lock and the output register.
// Depends on mssd_pkg.
module mssd_back import mssd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  logic [7:0]        store [NUM_DIGITS];
  logic [SCAN_W-1:0] scan_index;
  logic              error_lock;

  logic [17:0]       rem_prod;
  logic [3:0]        ones;
  logic [3:0]        tenths;
  logic [7:0]        temp_glyph [4];
  logic [7:0]        err_glyph  [4];
  result_t           res_next;
  logic              fire;

  assign item_pop = item_valid && (!res_valid || res_ready);
  assign fire     = item_pop;

  always_comb begin
    // rem / 10 == (rem * 205) >> 11 for rem < 100
    rem_prod      = 18'(item.rem) * 18'd205;
    ones          = rem_prod[14:11];
    tenths        = 4'(item.rem - 7'(ones) * 7'd10);
    temp_glyph[0] = (item.hund == 4'd0) ? GLYPH_BLANK : numeral_glyph(item.hund);
    temp_glyph[1] = numeral_glyph(ones) | SEG_DP;
    temp_glyph[2] = numeral_glyph(tenths);
    temp_glyph[3] = GLYPH_UPPER_C;
    err_glyph[0]  = GLYPH_UPPER_E;
    err_glyph[1]  = GLYPH_LOWER_R;
    err_glyph[2]  = GLYPH_LOWER_R;
    err_glyph[3]  = (item.code <= CODE_MAX_DIG) ? numeral_glyph(item.code) : GLYPH_BLANK;

    res_next = '0;
    unique case (item.op)
      OP_TICK: begin
        res_next.seg_code     = store[scan_index];
        res_next.digit_select = select_byte(int'(scan_index));
        res_next.latch_pulse  = 1'b1;
      end
      OP_TEMP: res_next.accepted = !error_lock;
      OP_ERR:  res_next.accepted = 1'b1;
      OP_NONE: res_next = '0;
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store[i] <= reset_glyph(i);
      end
      scan_index <= '0;
      error_lock <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= fire || (res_valid && !res_ready);
      if (fire) begin
        unique case (item.op)
          OP_TICK: begin
            scan_index <= (scan_index == SCAN_W'(NUM_DIGITS-1)) ? '0 : scan_index + 1'b1;
          end
          OP_TEMP: begin
            if (!error_lock) begin
              for (int i = 0; i < NUM_DIGITS && i < 4; i++) begin
                store[i] <= temp_glyph[i];
              end
            end
          end
          OP_ERR: begin
            for (int i = 0; i < NUM_DIGITS && i < 4; i++) begin
              store[i] <= err_glyph[i];
            end
            error_lock <= (item.code != CODE_OK);
          end
          OP_NONE: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/muxed_seven_segment_temp_display.sv =====
// Top level of the multiplexed seven-segment temperature display driver.
// Each input beat is registered in the queue and then in the back-end output register;
// one beat per cycle sustained while m_tready is high. Reset (synchronous, active high)
// loads digits 1,2,3,5, clears scan index, error lock, queue and output valid.
// Depends on mssd_pkg, mssd_front, mssd_queue, mssd_back.
module muxed_seven_segment_temp_display import mssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // temp_tenths[9:0], error_code[13:10], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // seg_code, digit_select, latch_pulse, accepted, pad
);

  item_t   front_item;
  item_t   head;
  logic    full;
  logic    empty;
  logic    pop;
  result_t res;

  mssd_front u_front (
    .op          (s_tuser),
    .temp_tenths (s_tdata[9:0]),
    .error_code  (s_tdata[13:10]),
    .item        (front_item)
  );

  assign s_tready = !full;

  mssd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && !full),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  mssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!empty),
    .item       (head),
    .item_pop   (pop),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  assign m_tdata = {6'd0, res.accepted, res.latch_pulse, res.digit_select, res.seg_code};

endmodule

// ===== tb/sv/muxed_seven_segment_temp_display_tb.sv =====
// Testbench for muxed_seven_segment_temp_display: directed and random beats, checked against
// a local predictor of the digit store, scan index and error lock.
// Depends on mssd_pkg and the RTL under rtl/.
module muxed_seven_segment_temp_display_tb;
  import mssd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // temp_tenths[9:0], error_code[13:10], zero pad
  logic [1:0]  s_tuser = '0;    // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // seg_code[7:0], digit_select[15:8], latch_pulse, accepted, pad

  muxed_seven_segment_temp_display dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted display state
  logic [7:0]        shown_glyph [NUM_DIGITS];
  logic [SCAN_W-1:0] scan_pos;
  logic              err_locked;
  result_t           expected_beats [$];

  int mismatches    = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;

  function automatic logic [7:0] decimal_glyph(input int d);
    case (d)
      0:       return SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      1:       return SEG_B | SEG_C;
      2:       return SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
      3:       return SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
      4:       return SEG_F | SEG_G | SEG_B | SEG_C;
      5:       return SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      6:       return SEG_A | SEG_F | SEG_G | SEG_E | SEG_D | SEG_C;
      7:       return SEG_A | SEG_B | SEG_C;
      8:       return SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      9:       return SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: return GLYPH_BLANK;
    endcase
  endfunction

  function automatic logic [7:0] select_line(input int idx);
    case (idx)
      0:       return 8'h04;
      1:       return 8'h20;
      2:       return 8'h08;
      3:       return 8'h40;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void reset_display_state();
    for (int i = 0; i < NUM_DIGITS; i++) shown_glyph[i] = GLYPH_BLANK;
    shown_glyph[0] = decimal_glyph(1);
    shown_glyph[1] = decimal_glyph(2);
    shown_glyph[2] = decimal_glyph(3);
    shown_glyph[3] = decimal_glyph(5);
    scan_pos   = '0;
    err_locked = 1'b0;
  endfunction

  function automatic result_t next_display_beat(input op_t op, input logic [9:0] temp,
                                                input logic [3:0] code);
    result_t    r;
    logic [9:0] t;
    r = '0;
    case (op)
      OP_TICK: begin
        r.seg_code     = shown_glyph[scan_pos];
        r.digit_select = select_line(int'(scan_pos));
        r.latch_pulse  = 1'b1;
        scan_pos = (int'(scan_pos) == NUM_DIGITS - 1) ? '0 : scan_pos + 1'b1;
      end
      OP_TEMP: begin
        if (!err_locked) begin
          t = (temp > TEMP_MAX) ? TEMP_MAX : temp;
          shown_glyph[0] = (t / 100 == 0) ? GLYPH_BLANK : decimal_glyph(int'(t / 100));
          shown_glyph[1] = decimal_glyph(int'((t / 10) % 10)) | SEG_DP;
          shown_glyph[2] = decimal_glyph(int'(t % 10));
          shown_glyph[3] = GLYPH_UPPER_C;
          r.accepted = 1'b1;
        end
      end
      OP_ERR: begin
        shown_glyph[0] = GLYPH_UPPER_E;
        shown_glyph[1] = GLYPH_LOWER_R;
        shown_glyph[2] = GLYPH_LOWER_R;
        shown_glyph[3] = (code <= CODE_MAX_DIG) ? decimal_glyph(int'(code)) : GLYPH_BLANK;
        err_locked = (code != CODE_OK);
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // one input beat; valid stays high until the next call or an idle cycle
  task automatic send_item(input op_t op, input logic [9:0] temp, input logic [3:0] code);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {2'b00, code, temp};
    do @(posedge clk); while (!s_tready);
    expected_beats.push_back(next_display_beat(op, temp, code));
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_item(OP_TICK, 10'($urandom), 4'($urandom));
  endtask

  task automatic send_random_item();
    int         r;
    op_t        op;
    logic [9:0] temp;
    logic [3:0] code;
    r    = $urandom_range(99);
    op   = (r < 45) ? OP_TICK : (r < 72) ? OP_TEMP : (r < 92) ? OP_ERR : OP_NONE;
    temp = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1000))
                                    : 10'($urandom_range(999, 0));
    code = ($urandom_range(2) == 0) ? CODE_OK : 4'($urandom_range(15, 1));
    send_item(op, temp, code);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off while hold_left counts down
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", m_tdata));
      end else begin
        want = expected_beats.pop_front();
        if (m_tdata[7:0] !== want.seg_code)
          report_mismatch($sformatf("seg_code %h, want %h", m_tdata[7:0], want.seg_code));
        if (m_tdata[15:8] !== want.digit_select)
          report_mismatch($sformatf("digit_select %h, want %h", m_tdata[15:8],
                                    want.digit_select));
        if (m_tdata[16] !== want.latch_pulse)
          report_mismatch($sformatf("latch_pulse %b, want %b", m_tdata[16], want.latch_pulse));
        if (m_tdata[17] !== want.accepted)
          report_mismatch($sformatf("accepted %b, want %b", m_tdata[17], want.accepted));
      end
    end
  end

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic test_reset_glyphs();
    send_ticks(5);
  endtask

  task automatic test_temp_extremes();
    send_item(OP_TEMP, 10'd1023, 4'hF);   // saturates to 99.9
    send_ticks(3);
    send_item(OP_TEMP, 10'd0, 4'h0);
    send_ticks(2);
    send_item(OP_TEMP, 10'd100, 4'h5);
    send_item(OP_TEMP, 10'd999, 4'hA);
    send_ticks(1);
  endtask

  task automatic test_error_lock();
    send_item(OP_ERR, 10'h3FF, 4'd10);    // generic blank, locks
    send_item(OP_TEMP, 10'd345, 4'h0);    // refused
    send_ticks(2);
    send_item(OP_ERR, 10'h000, 4'd15);
    send_item(OP_ERR, 10'h155, 4'd9);
    send_item(OP_ERR, 10'h2AA, CODE_OK);  // unlocks
    send_item(OP_TEMP, 10'd207, 4'hF);
    send_ticks(2);
  endtask

  task automatic test_unused_op();
    send_item(OP_NONE, 10'h3FF, 4'hF);
    send_item(OP_NONE, 10'h000, 4'h0);
  endtask

  task automatic test_back_pressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    @(posedge clk);
    hold_left = 200;
    for (int i = 0; i < 40; i++) send_random_item();
    wait_drained();
  endtask

  task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int i = 0; i < n; i++) send_random_item();
    wait_drained();
  endtask

  initial begin
    reset_display_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_glyphs();
    test_temp_extremes();
    test_error_lock();
    test_unused_op();
    wait_drained();
    test_random(270, 0, 0);
    test_back_pressure();
    test_random(150, 85, 0);
    test_random(150, 0, 85);
    test_random(270, 35, 35);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mssd_pkg.sv
rtl/mssd_front.sv
rtl/mssd_queue.sv
rtl/mssd_back.sv
rtl/muxed_seven_segment_temp_display.sv
tb/sv/muxed_seven_segment_temp_display_tb.sv
